// File: hdl/tvws_pkg.sv
// Shared types, constants and the quarter-wave cosine table of the three-voice synth.
// No dependencies.

package tvws_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int COS_DEPTH     = 256;
    localparam int COS_IDX_BITS  = $clog2(COS_DEPTH);
    localparam int VOICES        = 3;
    localparam int CFG_BITS      = 32;
    localparam int AMP_BITS      = 14;
    localparam int WAVE_BITS     = 17;
    localparam int FRAC_BITS     = 15;
    localparam int PROD_BITS     = AMP_BITS + 1 + WAVE_BITS;
    localparam int SUM_BITS      = PROD_BITS + 2;
    localparam int SAMPLE_BITS   = 16;
    localparam int TRI_BITS      = 16;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [PHASE_BITS-1:0]       phase_t;
    typedef logic signed [WAVE_BITS-1:0] wave_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic [AMP_BITS-1:0]         amp_t;
    typedef logic [15:0]                 cos_entry_t;
    typedef cos_entry_t                  cos_rom_t [COS_DEPTH+1];
    typedef wave_t                       wave_vec_t [VOICES];

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_COSINE   = 2'd2,
        WAVE_OFF      = 2'd3
    } waveform_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TUNING_A  = 3'd0,
        REG_TUNING_B  = 3'd1,
        REG_TUNING_C  = 3'd2,
        REG_OFFSET    = 3'd3,
        REG_AMPLITUDE = 3'd4,
        REG_WAVEFORM  = 3'd5
    } cfg_reg_t;

    localparam wave_t WAVE_ONE = wave_t'(32768);

    localparam logic [CFG_BITS-1:0] TUNING_RESET    = 32'd35163475;
    localparam amp_t                AMPLITUDE_RESET = amp_t'(5333);

    // Q30 Taylor series of cos, eight terms, rounded to Q15 and clamped.
    function automatic cos_entry_t cos_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        th;
        logic [63:0]        th2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x    = (64'(k) << 30) / COS_DEPTH;
        th   = (x * HALF_PI_Q30) >> 30;
        th2  = (th * th) >> 30;
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        term = ((term * th2) >> 30) / 64'd2;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd12;
        acc  = acc + $signed(term);
        term = ((term * th2) >> 30) / 64'd30;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd56;
        acc  = acc + $signed(term);
        term = ((term * th2) >> 30) / 64'd90;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd132;
        acc  = acc + $signed(term);
        term = ((term * th2) >> 30) / 64'd182;
        acc  = acc - $signed(term);
        if (acc < 0)
        begin
            acc = 64'sd0;
        end
        acc = (acc + (64'sd1 << 14)) >>> 15;
        if (acc > 64'sd32768)
        begin
            acc = 64'sd32768;
        end
        return cos_entry_t'(acc);
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        for (int unsigned k = 0; k <= COS_DEPTH; k++)
        begin
            rom[k] = cos_entry(k);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// File: hdl/tvws_voice.sv
// One voice: phase accumulator and wave shaper with a registered wave value.
// Depends on tvws_pkg.

module tvws_voice (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               restart,
    input  logic [tvws_pkg::CFG_BITS-1:0]      tuning_word,
    input  logic [tvws_pkg::CFG_BITS-1:0]      phase_offset,
    input  tvws_pkg::waveform_t                waveform,
    output tvws_pkg::wave_t                    wave
);
    import tvws_pkg::*;

    phase_t                  phase_reg;
    phase_t                  phase_base;
    phase_t                  phase_next;
    phase_t                  p;
    phase_t                  tri_fold;
    logic [1:0]              quad;
    logic                    low_zero;
    logic [TRI_BITS-1:0]     tri_top;
    logic [COS_IDX_BITS-1:0] cos_i;
    logic [COS_IDX_BITS:0]   cos_idx;
    wave_t                   cos_mag;
    wave_t                   wave_next;
    wave_t                   wave_reg;

    assign phase_base = restart ? '0 : phase_reg;
    assign phase_next = phase_base + phase_t'(tuning_word);
    assign p          = phase_base + phase_t'(phase_offset);

    assign quad     = p[PHASE_BITS-1 -: 2];
    assign low_zero = (p[PHASE_BITS-3:0] == '0);

    assign tri_fold = (p <= (phase_t'(1) << (PHASE_BITS-1))) ? p : (phase_t'(0) - p);
    assign tri_top  = tri_fold[PHASE_BITS-1 -: TRI_BITS];

    assign cos_i   = p[PHASE_BITS-3 -: COS_IDX_BITS];
    assign cos_idx = quad[0] ? ((COS_IDX_BITS+1)'(COS_DEPTH) - {1'b0, cos_i})
                             : {1'b0, cos_i};
    assign cos_mag = wave_t'(COS_ROM[cos_idx]);

    always_comb
    begin
        wave_next = '0;
        unique case (waveform)
            WAVE_SQUARE:
            begin
                if (low_zero && quad[0])
                begin
                    wave_next = '0;
                end
                else
                begin
                    wave_next = (quad[1] ^ quad[0]) ? -WAVE_ONE : WAVE_ONE;
                end
            end
            WAVE_TRIANGLE:
            begin
                wave_next = WAVE_ONE - wave_t'({tri_top, 1'b0});
            end
            WAVE_COSINE:
            begin
                wave_next = (quad[1] ^ quad[0]) ? -cos_mag : cos_mag;
            end
            default:
            begin
                wave_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wave_reg <= wave_next;
        end
    end

    assign wave = wave_reg;

endmodule

// File: hdl/tvws_mix.sv
// Gain, three-way sum, scaling and saturation with the output register.
// Depends on tvws_pkg.

module tvws_mix (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wave_valid,
    output logic                                 wave_ready,
    input  tvws_pkg::wave_vec_t                  waves,
    input  tvws_pkg::amp_t                       amplitude,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tvws_pkg::SAMPLE_BITS-1:0]     sample,
    output logic                                 clipped
);
    import tvws_pkg::*;

    localparam int MAG_BITS = SUM_BITS - FRAC_BITS;

    prod_t                   prod_reg [VOICES];
    logic                    prod_valid_reg;
    logic                    out_valid_reg;
    logic                    out_ready;
    sum_t                    sum;
    logic                    neg;
    sum_t                    abs_sum;
    logic [MAG_BITS-1:0]     mag;
    logic [SAMPLE_BITS-1:0]  sample_next;
    logic                    clip_next;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic                    clip_reg;

    assign out_ready  = m_tready || !out_valid_reg;
    assign wave_ready = !prod_valid_reg || out_ready;

    assign sum = sum_t'(prod_reg[0]) + sum_t'(prod_reg[1]) + sum_t'(prod_reg[2]);
    assign neg     = sum[SUM_BITS-1];
    assign abs_sum = neg ? -sum : sum;
    assign mag     = abs_sum[SUM_BITS-1:FRAC_BITS];

    always_comb
    begin
        clip_next   = 1'b0;
        sample_next = mag[SAMPLE_BITS-1:0];
        if (neg)
        begin
            if (mag > MAG_BITS'(32768))
            begin
                clip_next   = 1'b1;
                sample_next = 16'h8000;
            end
            else
            begin
                sample_next = SAMPLE_BITS'(-mag);
            end
        end
        else if (mag > MAG_BITS'(32767))
        begin
            clip_next   = 1'b1;
            sample_next = 16'h7FFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wave_ready)
            begin
                prod_valid_reg <= wave_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wave_valid && wave_ready)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                prod_reg[v] <= $signed({1'b0, amplitude}) * waves[v];
            end
        end
        if (prod_valid_reg && out_ready)
        begin
            sample_reg <= sample_next;
            clip_reg   <= clip_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign sample   = sample_reg;
    assign clipped  = clip_reg;

endmodule

// File: hdl/three_voice_waveform_synth.sv
// Top level of the three-voice waveform synthesizer: configuration registers,
// stream ports and the voice and mixer stages. Depends on tvws_pkg, tvws_voice, tvws_mix.

// Each accepted input transfer produces one signed 16-bit sample, the saturated sum of
// three DDS voices (square, triangle, quarter-wave cosine or off, which gives zero) scaled
// by a common gain. Throughput is one sample per clock while m_tready stays high; a transfer
// passes the wave register, the product register and the output register before the sample
// is offered on m_tdata.
// Bit 0 of s_tdata restarts all phase accumulators before the sample is taken.
// Write configuration only while no sample is in flight.

module three_voice_waveform_synth (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [0] restart_phase, [7:1] zero
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tvws_pkg::SAMPLE_BITS-1:0]     m_tdata,   // [15:0] sample
    output logic                                 m_tuser,   // [0] clipped
    input  logic                                 cfg_we,
    input  logic [tvws_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tvws_pkg::CFG_BITS-1:0]        cfg_data
);
    import tvws_pkg::*;

    logic [CFG_BITS-1:0] tuning_reg [VOICES];
    logic [CFG_BITS-1:0] offset_reg;
    amp_t                amplitude_reg;
    waveform_t           waveform_reg;
    logic                wave_valid_reg;
    logic                mix_ready;
    logic                accept;
    wave_vec_t           waves;

    assign s_tready = !wave_valid_reg || mix_ready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                tuning_reg[v] <= TUNING_RESET;
            end
            offset_reg    <= '0;
            amplitude_reg <= AMPLITUDE_RESET;
            waveform_reg  <= WAVE_SQUARE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TUNING_A:  tuning_reg[0] <= cfg_data;
                REG_TUNING_B:  tuning_reg[1] <= cfg_data;
                REG_TUNING_C:  tuning_reg[2] <= cfg_data;
                REG_OFFSET:    offset_reg    <= cfg_data;
                REG_AMPLITUDE: amplitude_reg <= cfg_data[AMP_BITS-1:0];
                REG_WAVEFORM:  waveform_reg  <= waveform_t'(cfg_data[1:0]);
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            wave_valid_reg <= s_tvalid;
        end
    end

    for (genvar v = 0; v < VOICES; v++)
    begin : g_voice
        tvws_voice u_voice (
            .clk          (clk),
            .rst_n        (rst_n),
            .accept       (accept),
            .restart      (s_tdata[0]),
            .tuning_word  (tuning_reg[v]),
            .phase_offset (offset_reg),
            .waveform     (waveform_reg),
            .wave         (waves[v])
        );
    end

    tvws_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .wave_valid (wave_valid_reg),
        .wave_ready (mix_ready),
        .waves      (waves),
        .amplitude  (amplitude_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .sample     (m_tdata),
        .clipped    (m_tuser)
    );

endmodule

// File: verif/three_voice_waveform_synth_tb.sv
// Self-checking testbench for the three-voice waveform synthesizer.
// Predicts every sample from its own phase accumulators and cosine table.
// Depends on tvws_pkg and three_voice_waveform_synth.
`timescale 1ns / 100ps

module three_voice_waveform_synth_tb;

    import tvws_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          RANDOM_ITEMS  = 1100;
    localparam int          PIPE_LATENCY  = 3;
    localparam int          HOLD_CYCLES   = 300;
    localparam logic [31:0] QTR_TURN      = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [31:0] THREE_QTR     = 32'hC000_0000;
    localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

    typedef struct {
        logic [15:0] sample;
        logic        clipped;
    } synth_out_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data  = 32'd0;

    logic [31:0] tune_word [VOICES];
    logic [31:0] voice_acc [VOICES];
    logic [31:0] phase_off;
    logic [13:0] gain;
    waveform_t   wave_sel;
    int          cos_q15 [COS_DEPTH+1];

    synth_out_t  expected_samples [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    bit          hold_request   = 1'b0;

    three_voice_waveform_synth DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void build_cos_q15();
        longint unsigned x;
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k <= COS_DEPTH; k++)
        begin
            x    = (longint'(k) << 30) / COS_DEPTH;
            th   = (x * HALF_PI_Q30) >> 30;
            th2  = (th * th) >> 30;
            term = 64'd1 << 30;
            acc  = 64'sd1 << 30;
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * th2) >> 30) / ((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            acc = (acc + (64'sd1 << 14)) / (64'sd1 << 15);
            if (acc > 32768)
            begin
                acc = 32768;
            end
            cos_q15[k] = int'(acc);
        end
    endfunction

    function automatic int voice_wave(input logic [31:0] p);
        logic [32:0] fold;
        logic [7:0]  idx;
        case (wave_sel)
            WAVE_SQUARE:
            begin
                if (p == QTR_TURN || p == THREE_QTR)
                begin
                    return 0;
                end
                return (p < QTR_TURN || p > THREE_QTR) ? 32768 : -32768;
            end
            WAVE_TRIANGLE:
            begin
                fold = (p <= HALF_TURN) ? {1'b0, p} : 33'h1_0000_0000 - {1'b0, p};
                return 32768 - 2 * int'(fold >> 16);
            end
            WAVE_COSINE:
            begin
                idx = p[29:22];
                case (p[31:30])
                    2'd0:    return cos_q15[idx];
                    2'd1:    return -cos_q15[COS_DEPTH - idx];
                    2'd2:    return -cos_q15[idx];
                    default: return cos_q15[COS_DEPTH - idx];
                endcase
            end
            default:
            begin
                return 0;
            end
        endcase
    endfunction

    function automatic synth_out_t predict_sample(input logic restart);
        longint     total;
        longint     mag;
        synth_out_t r;
        total = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (restart)
            begin
                voice_acc[v] = 32'd0;
            end
            total        = total + longint'(gain) * longint'(voice_wave(voice_acc[v] + phase_off));
            voice_acc[v] = voice_acc[v] + tune_word[v];
        end
        mag       = (total < 0) ? -total : total;
        mag       = mag >> 15;
        r.clipped = 1'b0;
        if (total < 0)
        begin
            if (mag > 32768)
            begin
                mag       = 32768;
                r.clipped = 1'b1;
            end
            r.sample = 16'(-mag);
        end
        else
        begin
            if (mag > 32767)
            begin
                mag       = 32767;
                r.clipped = 1'b1;
            end
            r.sample = 16'(mag);
        end
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_TUNING_A:  tune_word[0] = data;
            REG_TUNING_B:  tune_word[1] = data;
            REG_TUNING_C:  tune_word[2] = data;
            REG_OFFSET:    phase_off    = data;
            REG_AMPLITUDE: gain         = data[13:0];
            REG_WAVEFORM:  wave_sel     = waveform_t'(data[1:0]);
            default:       ;
        endcase
    endtask

    task automatic send_item(input logic restart);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        burst_left--;
        expected_samples.push_back(predict_sample(restart));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (expected_samples.size() == 0);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic probe_phase(input logic [31:0] off);
        drain();
        write_reg(REG_OFFSET, off);
        send_item(1'b1);
    endtask

    task automatic test_reset_defaults();
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
    endtask

    task automatic test_square_wave();
        drain();
        write_reg(REG_TUNING_A, 32'd0);
        write_reg(REG_TUNING_B, 32'd0);
        write_reg(REG_TUNING_C, 32'd0);
        write_reg(REG_AMPLITUDE, 32'h0000_3FFF);
        write_reg(REG_WAVEFORM, {30'd0, WAVE_SQUARE});
        probe_phase(32'd0);
        probe_phase(QTR_TURN);
        probe_phase(THREE_QTR);
        probe_phase(HALF_TURN);
        probe_phase(QTR_TURN - 32'd1);
        probe_phase(QTR_TURN + 32'd1);
    endtask

    task automatic test_triangle_wave();
        drain();
        write_reg(REG_AMPLITUDE, 32'd5333);
        write_reg(REG_WAVEFORM, {30'd0, WAVE_TRIANGLE});
        probe_phase(32'd0);
        probe_phase(HALF_TURN);
        probe_phase(32'hFFFF_FFFF);
        probe_phase(QTR_TURN);
        probe_phase(32'h0001_0000);
    endtask

    task automatic test_cosine_wave();
        drain();
        write_reg(REG_AMPLITUDE, 32'd10000);
        write_reg(REG_WAVEFORM, {30'd0, WAVE_COSINE});
        probe_phase(32'd0);
        probe_phase(QTR_TURN);
        probe_phase(HALF_TURN);
        probe_phase(THREE_QTR);
        probe_phase(32'h3FC0_0000);
    endtask

    task automatic test_unused_waveform();
        drain();
        write_reg(REG_AMPLITUDE, 32'h0000_3FFF);
        write_reg(REG_WAVEFORM, {30'd0, WAVE_OFF});
        write_reg(REG_TUNING_A, TUNING_RESET);
        send_item(1'b1);
        send_item(1'b0);
    endtask

    task automatic test_register_edges();
        drain();
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        write_reg(REG_AMPLITUDE, 32'hFFFF_C000 | 32'd1234);
        write_reg(REG_WAVEFORM, {30'h3FFF_FFFF, WAVE_TRIANGLE});
        write_reg(REG_TUNING_A, 32'd0);
        write_reg(REG_TUNING_B, 32'hFFFF_FFFF);
        write_reg(REG_TUNING_C, HALF_TURN);
        write_reg(REG_OFFSET, 32'd0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
    endtask

    task automatic randomize_config();
        logic [2:0]  tune_reg [VOICES];
        logic [31:0] data;
        tune_reg = '{REG_TUNING_A, REG_TUNING_B, REG_TUNING_C};
        for (int v = 0; v < VOICES; v++)
        begin
            case ($urandom_range(0, 5))
                0:       data = 32'd0;
                1:       data = 32'hFFFF_FFFF;
                2:       data = $urandom;
                default: data = $urandom_range(0, 32'h0400_0000);
            endcase
            write_reg(tune_reg[v], data);
        end
        case ($urandom_range(0, 3))
            0:       data = 32'd0;
            1:       data = {2'($urandom_range(0, 3)), 30'd0};
            default: data = $urandom;
        endcase
        write_reg(REG_OFFSET, data);
        case ($urandom_range(0, 4))
            0:       data = 32'd0;
            1:       data = 32'h0000_3FFF;
            default: data = $urandom;
        endcase
        write_reg(REG_AMPLITUDE, data);
        data = $urandom;
        data[1:0] = ($urandom_range(0, 9) == 0) ? WAVE_OFF : 2'($urandom_range(0, 2));
        write_reg(REG_WAVEFORM, data);
    endtask

    task automatic test_input_backpressure();
        drain();
        randomize_config();
        hold_request = 1'b1;
        repeat (80) send_item($urandom_range(0, 19) == 0);
    endtask

    task automatic test_random_sweep();
        int sent;
        int run_len;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            randomize_config();
            run_len = $urandom_range(60, 200);
            repeat (run_len) send_item($urandom_range(0, 19) == 0);
            sent += run_len;
        end
    endtask

    initial
    begin : sample_checker
        synth_out_t  want;
        logic [15:0] ready_pattern;
        int          mode;
        int          hold_left;
        int          rx_cycle;
        ready_pattern = 16'hFFFF;
        mode          = 0;
        hold_left     = 0;
        rx_cycle      = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual sample %0d clipped %0b",
                             $time, $signed(m_tdata), m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want.sample)
                    begin
                        $display("%0t: sample mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.sample), $signed(m_tdata));
                        mismatch_count++;
                    end
                    if (m_tuser !== want.clipped)
                    begin
                        $display("%0t: clipped mismatch, expected %0b, actual %0b",
                                 $time, want.clipped, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            rx_cycle++;
            if (rx_cycle % 64 == 0)
            begin
                mode          = $urandom_range(0, 3);
                ready_pattern = 16'($urandom) | 16'd1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_tready    <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ready_pattern[rx_cycle % 16];
                    2:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    initial
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            tune_word[v] = TUNING_RESET;
            voice_acc[v] = 32'd0;
        end
        phase_off = 32'd0;
        gain      = AMPLITUDE_RESET;
        wave_sel  = WAVE_SQUARE;
        build_cos_q15();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_square_wave();
        test_triangle_wave();
        test_cosine_wave();
        test_unused_waveform();
        test_register_edges();
        test_input_backpressure();
        test_random_sweep();
        drain();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/tvws_pkg.sv
hdl/tvws_voice.sv
hdl/tvws_mix.sv
hdl/three_voice_waveform_synth.sv
verif/three_voice_waveform_synth_tb.sv
